FILE: rtl/core/rbbf_pkg.sv
// rbbf_pkg: constants, types and helpers shared by the box blur core.
// No dependencies.
`timescale 1ns / 1ps
package rbbf_pkg;
	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT     = 2048;
	localparam int POS_W          = 11;
	localparam int PIX_W          = 24;
	localparam int CFG_W          = 12;
	localparam int IDX_W          = 2;
	localparam int KS_W           = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KSIZE  = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// sum of one column of the window, per channel (max 7*255)
	typedef struct packed {
		logic [11:0] r;
		logic [11:0] g;
		logic [11:0] b;
	} csum_t;

	// reciprocal of k*k, 20 fraction bits, rounded up; exact floor for sums up to 255 * area
	// k = 1 is a pass-through and does not use the multiply
	function automatic logic [19:0] recip(input logic [3:0] k);
		case (k)
			4'd1:    recip = 20'hFFFFF;
			4'd2:    recip = 20'd262144;
			4'd3:    recip = 20'd116509;
			4'd4:    recip = 20'd65536;
			4'd5:    recip = 20'd41944;
			4'd6:    recip = 20'd29128;
			4'd7:    recip = 20'd21400;
			default: recip = 20'd21400;
		endcase
	endfunction
endpackage

FILE: rtl/core/rbbf_ram.sv
// rbbf_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rbbf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/rbbf_cell.sv
// rbbf_cell: one window column cell; holds a vertical strip sum, passes it on.
// Depends on rbbf_pkg.
`timescale 1ns / 1ps
module rbbf_cell import rbbf_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  csum_t sum_in,
	output csum_t sum_q
);
	always_ff @(posedge clk) begin
		if (en) sum_q <= sum_in;
	end
endmodule

FILE: rtl/core/rgb_box_blur_filter_core.sv
// rgb_box_blur_filter_core: top level of the streaming k x k RGB box blur.
// Depends on rbbf_pkg, rbbf_ram, rbbf_cell.
`timescale 1ns / 1ps
// Each beat is one pixel in row-major order. An accepted pixel passes four
// stages to its result: line store read, column sum into the cell chain, window
// sum, then divide and output register. One pixel is in flight at a time: the
// next beat is taken only once the sequencer is back at idle. Line stores are
// MAX_KERNEL-1 RAMs of MAX_WIDTH pixels, unwritten on reset (borders are never
// emitted, so no stale entry feeds a result within a frame). The window is a
// chain of MAX_KERNEL cells holding per-column strip sums; the newest column
// enters at the head and the window sum adds the k newest cells. Results sit in
// an output register; the next pixel is taken once that register is free or
// draining.
// tdata in, from bit 0 up: red, green, blue.
// tdata out, from bit 0 up: out_col, out_row, red, green, blue, two zero bits.
module rgb_box_blur_filter_core import rbbf_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// out_col[10:0], out_row[21:11], red[29:22], green[37:30], blue[45:38], zero[47:46]
	output logic [47:0]       m_axis_tdata
);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int NLS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

	logic [CFG_W-1:0] width_q, height_q;
	logic [KS_W-1:0]  ksize_q;
	logic [CFG_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
			ksize_q  <= KS_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_KSIZE:  ksize_q  <= cfg_data[KS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [3:0]  k_eff;
	logic [13:0] w_eff;
	logic [12:0] h_eff;
	always_comb begin
		k_eff = (ksize_q == '0) ? 4'd1 : 4'(ksize_q);
		if (k_eff > 4'(MAX_KERNEL)) k_eff = 4'(MAX_KERNEL);
		w_eff = (width_q == '0) ? 14'd1 : 14'(width_q);
		if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
		h_eff = (height_q == '0) ? 13'd1 : 13'(height_q);
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
	end

	// sequencer
	logic [3:0] st_q;   // one-hot: s1 read, s2 colsum, s3 window sum, s4 divide
	logic       s_acc;
	logic       out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (st_q == 4'd0) && out_free;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	pix_t             pix_s1;
	logic [CFG_W-1:0] col_s1;
	logic [POS_W-1:0] row_s1;
	logic [AW-1:0]    idx_s1;
	logic [AW-1:0]    idx_in;
	assign idx_in = (14'(col_q) >= 14'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : AW'(col_q);

	// line stores: RAM r holds the pixel r+1 rows above
	pix_t ls_rd [NLS];
	logic ls_we;
	assign ls_we = st_q[1];
	genvar gi;
	generate
		for (gi = 0; gi < NLS; gi++) begin : g_ls
			rbbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
				.clk  (clk),
				.we   (ls_we && (MAX_KERNEL > 1)),
				.waddr(idx_s1),
				.wdata((gi == 0) ? pix_s1 : ls_rd[(gi == 0) ? 0 : gi - 1]),
				.re   (s_acc),
				.raddr(idx_in),
				.rdata(ls_rd[gi])
			);
		end
	endgenerate

	// column strip sum of the k newest rows
	csum_t colsum;
	always_comb begin
		colsum.r = 12'(pix_s1[7:0]);
		colsum.g = 12'(pix_s1[15:8]);
		colsum.b = 12'(pix_s1[23:16]);
		for (int r = 1; r < MAX_KERNEL; r++) begin
			if (4'(r) < k_eff) begin
				colsum.r = colsum.r + 12'(ls_rd[r-1][7:0]);
				colsum.g = colsum.g + 12'(ls_rd[r-1][15:8]);
				colsum.b = colsum.b + 12'(ls_rd[r-1][23:16]);
			end
		end
	end

	// cell chain, cell 0 newest
	csum_t cell_q [MAX_KERNEL];
	generate
		for (gi = 0; gi < MAX_KERNEL; gi++) begin : g_cell
			rbbf_cell u_cell (
				.clk   (clk),
				.en    (st_q[1]),
				.sum_in((gi == 0) ? colsum : cell_q[(gi == 0) ? 0 : gi - 1]),
				.sum_q (cell_q[gi])
			);
		end
	endgenerate

	logic [14:0] wsr, wsg, wsb;
	always_comb begin
		wsr = '0; wsg = '0; wsb = '0;
		for (int c = 0; c < MAX_KERNEL; c++) begin
			if (4'(c) < k_eff) begin
				wsr = wsr + 15'(cell_q[c].r);
				wsg = wsg + 15'(cell_q[c].g);
				wsb = wsb + 15'(cell_q[c].b);
			end
		end
	end

	logic [14:0] sr_s3, sg_s3, sb_s3;
	logic        emit_s1, emit_s2, emit_s3;
	logic [POS_W-1:0] oc_s2, or_s2, oc_s3, or_s3;
	logic [19:0] rc;
	assign rc = recip(k_eff);

	function automatic logic [7:0] qdiv(input logic [14:0] s, input logic [19:0] m,
		input logic one);
		logic [34:0] p;
		p = 35'(s) * 35'(m);
		qdiv = one ? s[7:0] : p[27:20];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			col_q <= '0;
			row_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			st_q <= {st_q[2:0], s_acc};
			if (s_acc) begin
				if (14'(col_q) + 14'd1 >= w_eff) begin
					col_q <= '0;
					row_q <= (13'(row_q) + 13'd1 >= h_eff) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (st_q[3] && emit_s3) m_axis_tvalid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1  <= s_axis_tdata;
			col_s1  <= col_q;
			row_s1  <= row_q;
			idx_s1  <= idx_in;
			emit_s1 <= (13'(col_q) + 13'd1 >= 13'(k_eff)) && (13'(row_q) + 13'd1 >= 13'(k_eff));
		end
		if (st_q[1]) begin
			emit_s2 <= emit_s1;
			oc_s2   <= POS_W'(col_s1 - CFG_W'(k_eff >> 1));
			or_s2   <= row_s1 - POS_W'(k_eff >> 1);
		end
		if (st_q[2]) begin
			emit_s3 <= emit_s2;
			oc_s3 <= oc_s2; or_s3 <= or_s2;
			sr_s3 <= wsr; sg_s3 <= wsg; sb_s3 <= wsb;
		end
		if (st_q[3] && emit_s3) begin
			m_axis_tdata <= {2'b00, qdiv(sb_s3, rc, k_eff == 4'd1),
				qdiv(sg_s3, rc, k_eff == 4'd1), qdiv(sr_s3, rc, k_eff == 4'd1), or_s3, oc_s3};
		end
	end
endmodule

FILE: rtl/core/rbbf_checker.sv
// rbbf_checker: port-level assertions for the box blur core, bound to the top.
// Depends on rgb_box_blur_filter_core.
`timescale 1ns / 1ps
module rbbf_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while pixel in flight");
	a_noout: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too early");
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("valid during reset");
endmodule

bind rgb_box_blur_filter_core rbbf_checker u_rbbf_checker (.*);

FILE: tb/sv/rbbf_checker.sv
// rbbf_scoreboard: watches the config port and both pixel streams of the box blur core,
// predicts each blurred pixel and compares it with what the core sends. Depends on rbbf_pkg.
`timescale 1ns / 1ps
module rbbf_scoreboard import rbbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [23:0]      s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [47:0]      m_axis_tdata,
	output int               fail_count,
	output int               pending,
	output int               blur_count
);
	typedef struct packed {
		logic [1:0]  pad;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [10:0] row;
		logic [10:0] col;
	} blur_px_t;

	localparam int MK = MAX_KERNEL_DEF;
	localparam int MW = MAX_WIDTH_DEF;

	logic [23:0] row_hist [MK][MW];   // [r][col]: r+1 rows above
	logic [23:0] strip [MK][MK];      // [c][r], newest column at MK-1
	int          pos_col, pos_row;
	logic [11:0] width_reg, height_reg;
	logic [2:0]  ksize_reg;
	blur_px_t    blur_q[$];
	int          mism;

	assign pending = blur_q.size();

	initial begin
		fail_count = 0;
		blur_count = 0;
		mism = 0;
	end

	// advance the model by one pixel; queue a blurred pixel when the window is full
	task automatic take_pixel(input logic [23:0] pix);
		int       k, w, h, idx, sr, sg, sb, area;
		blur_px_t px;
		k = (ksize_reg == 0) ? 1 : ksize_reg;
		w = (width_reg == 0) ? 1 : ((width_reg > MW) ? MW : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		idx = (pos_col < MW) ? pos_col : MW - 1;
		for (int c = 0; c < MK - 1; c++)
			for (int r = 0; r < MK; r++)
				strip[c][r] = strip[c+1][r];
		strip[MK-1][0] = pix;
		for (int r = 1; r < MK; r++)
			strip[MK-1][r] = row_hist[r-1][idx];
		for (int r = MK - 1; r > 0; r--)
			row_hist[r][idx] = row_hist[r-1][idx];
		row_hist[0][idx] = pix;
		if (pos_col >= k - 1 && pos_row >= k - 1) begin
			sr = 0; sg = 0; sb = 0;
			area = k * k;
			for (int c = MK - k; c < MK; c++)
				for (int r = 0; r < k; r++) begin
					sr += strip[c][r][7:0];
					sg += strip[c][r][15:8];
					sb += strip[c][r][23:16];
				end
			px.pad   = '0;
			px.col   = 11'(pos_col - k / 2);
			px.row   = 11'(pos_row - k / 2);
			px.red   = 8'(sr / area);
			px.green = 8'(sg / area);
			px.blue  = 8'(sb / area);
			blur_q.insert(blur_q.size(), px);
		end
		if (pos_col + 1 >= w) begin
			pos_col = 0;
			pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_px_t got, want;
		if (!arst_n) begin
			pos_col = 0;
			pos_row = 0;
			width_reg = 12'd640;
			height_reg = 12'd480;
			ksize_reg = 3'd3;
			blur_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_KSIZE:  ksize_reg = cfg_data[2:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				take_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				blur_count++;
				if (blur_q.size() == 0) begin
					fail_count++;
					if (++mism <= 10)
						$display("ERROR: unexpected beat %h", m_axis_tdata);
				end else begin
					want = blur_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (++mism <= 10)
							$display("ERROR: col %0d/%0d row %0d/%0d rgb %h%h%h/%h%h%h (exp/act)",
								want.col, got.col, want.row, got.row, want.red, want.green,
								want.blue, got.red, got.green, got.blue);
					end
				end
			end
		end
	end
endmodule

FILE: tb/sv/tb.sv
// tb: stimulus and verdict for rgb_box_blur_filter_core; rbbf_scoreboard does the checking.
// Depends on rbbf_pkg, rbbf_scoreboard and the core RTL.
`timescale 1ns / 1ps
module tb;
	import rbbf_pkg::*;

	localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side and no config write
	localparam int DRAIN_WAIT  = 12;    // idle cycles after every expected blurred pixel has drained

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [47:0]      m_axis_tdata;   // out_col[10:0], out_row, red, green, blue, zero
	int               fail_count, pending, blur_count;

	int tx_idle, rx_idle;   // idle percentages of sender and receiver
	bit hold_req;           // asks the receiver for one long hold-off
	int pixels_sent, frames_sent;

	rgb_box_blur_filter_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	rbbf_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending(pending), .blur_count(blur_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_req = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// watchdog: ends the run if nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else if (++quiet >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d pending", quiet, pending);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// mostly random pixels, sometimes saturated or black
	function automatic logic [23:0] pick_pixel();
		case ($urandom_range(7))
			0:       return 24'hFFFFFF;
			1:       return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [23:0] pix);
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
	endtask

	// sender pause: let every queued blurred pixel drain, then a few idle cycles
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// one setting, then whole frames only, so the line stores never serve stale rows
	task automatic run_setting(input logic [11:0] w, input logic [11:0] h,
			input logic [2:0] k, input int frames);
		int ew, eh;
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_KSIZE, {9'd0, k});
		ew = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
		eh = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
		repeat (frames) begin
			repeat (ew * eh) send_pixel(pick_pixel());
			frames_sent++;
		end
	endtask

	initial begin
		int start_px;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_WIDTH;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		hold_req = 0;
		tx_idle = 33;
		rx_idle = 87;
		pixels_sent = 0;
		frames_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero sizes act as one, pass-through kernel
		run_setting(12'd0, 12'd0, 3'd0, 3);
		run_setting(12'd4, 12'd3, 3'd2, 1);
		// largest kernel exactly fills the frame: one output
		run_setting(12'd7, 12'd7, 3'd7, 1);
		// kernel wider than frame: nothing comes out
		run_setting(12'd5, 12'd9, 3'd7, 1);
		run_setting(12'd3, 12'd3, 3'd4, 1);
		run_setting(12'd6, 12'd4, 3'd3, 2);

		// long receiver hold while the sender keeps pushing a frame that emits early
		drain();
		hold_req = 1;
		run_setting(12'd8, 12'd6, 3'd3, 1);

		start_px = pixels_sent;
		while (pixels_sent - start_px < 750) begin
			if (pixels_sent - start_px < 250) begin
				tx_idle = 33; rx_idle = 87;
			end else if (pixels_sent - start_px < 500) begin
				tx_idle = 87; rx_idle = 33;
			end else begin
				tx_idle = 0; rx_idle = 0;
			end
			run_setting(12'($urandom_range(1, 16)), 12'($urandom_range(1, 10)),
				3'($urandom_range(0, 7)), $urandom_range(1, 2));
		end
		drain();

		$display("covered %0d pixels in %0d frames, %0d blurred pixels checked",
			pixels_sent, frames_sent, blur_count);
		$display("kernel 0..7, zero frame sizes, idle mixes and a long hold-off");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/rbbf_pkg.sv
rtl/core/rbbf_ram.sv
rtl/core/rbbf_cell.sv
rtl/core/rgb_box_blur_filter_core.sv
rtl/core/rbbf_checker.sv
tb/sv/rbbf_checker.sv
tb/sv/tb.sv
